[hw/rtl/porm_pkg.sv]
package porm_pkg;

    // fixed widths of the channel fields
    localparam int PORT_W = 16;
    localparam int WL_W   = 22;

    // wirelength saturates here
    localparam logic [WL_W-1:0] WL_MAX = '1;

    // strobes from the sequencer to the net accumulator
    typedef struct packed {
        logic pin_take;    // pin transfer: update box or self position
        logic fin_span;    // net end, step 1: store bounds, compute spans
        logic fin_sum;     // net end, step 2: add spans into wirelength
        logic clear_cell;  // result loaded for output: back to per-cell reset
    } t_acc_ctrl;

    // status of the median selection unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_sel_stat;

endpackage

[hw/rtl/porm_if.sv]
interface porm_pin_if;
    logic                         valid;
    logic                         ready;
    logic [porm_pkg::PORT_W-1:0]  pin_x;
    logic [porm_pkg::PORT_W-1:0]  pin_y;
    logic                         is_self;
    logic                         last_pin;
    logic                         last_net;

    modport source (output valid, pin_x, pin_y, is_self, last_pin, last_net, input ready);
    modport sink   (input valid, pin_x, pin_y, is_self, last_pin, last_net, output ready);
endinterface

interface porm_res_if;
    logic                         valid;
    logic                         ready;
    logic [porm_pkg::PORT_W-1:0]  left_edge;
    logic [porm_pkg::PORT_W-1:0]  right_edge;
    logic [porm_pkg::PORT_W-1:0]  top_edge;
    logic [porm_pkg::PORT_W-1:0]  bottom_edge;
    logic [porm_pkg::WL_W-1:0]    cell_wirelength;
    logic                         net_overflow;

    modport source (output valid, left_edge, right_edge, top_edge, bottom_edge,
                    cell_wirelength, net_overflow, input ready);
    modport sink   (input valid, left_edge, right_edge, top_edge, bottom_edge,
                    cell_wirelength, net_overflow, output ready);
endinterface

[hw/rtl/placement_optimal_region_median_core.sv]
// Channel   Dir  Modport  Transfer when       Payload
// i_pin     in   sink     valid && ready      pin_x, pin_y, is_self, last_pin, last_net
// o_res     out  source   valid && ready      four region edges, cell_wirelength, net_overflow
//
// Steps: a pin inside a net is a box update; a pin that ends a net goes
//   through box update, bound store plus spans, and wirelength add.
// End of list: the median search ranks each of the 2N stored bounds against
//   all 2N, itself included, through one comparator, on each of the 2 axes.
// Reset: i_rst_n synchronous, active low; clears control state and the
//   per-cell box, counts and flags. Bound stores are not cleared.
// Stalls: i_pin.ready is low while a net closes, a search runs or a result waits to load.
//   A result waits in the output register; the next cell's pins are taken
//   meanwhile, and a second result waits until the first transfers.
module placement_optimal_region_median_core #(
    parameter int MAX_NETS   = 32,
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    porm_pin_if.sink   i_pin,
    porm_res_if.source o_res
);

    localparam int IDX_W = (MAX_NETS > 1) ? $clog2(MAX_NETS) : 1;
    localparam int CNT_W = $clog2(MAX_NETS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // taking pins
    localparam logic [2:0] S_SPAN = 3'd1;  // store bounds, spans of the box with the cell
    localparam logic [2:0] S_SUM  = 3'd2;  // accumulate wirelength
    localparam logic [2:0] S_SEL  = 3'd3;  // median search running
    localparam logic [2:0] S_DONE = 3'd4;  // load output register

    logic [2:0] r_state;
    logic       r_last_net;
    logic       r_ov;

    // output payload register
    logic [porm_pkg::PORT_W-1:0] r_left, r_right, r_top, r_bottom;
    logic [porm_pkg::WL_W-1:0]   r_wl;
    logic                        r_ovf;

    porm_pkg::t_acc_ctrl w_acc;
    porm_pkg::t_sel_stat w_sel_stat;

    logic                        w_pin_xfer;
    logic                        w_out_xfer;
    logic                        w_load;
    logic                        w_start;
    logic [COORD_BITS-1:0]       w_x, w_y;
    logic                        w_we;
    logic [IDX_W-1:0]            w_waddr;
    logic [COORD_BITS-1:0]       w_xlo, w_xhi, w_ylo, w_yhi;
    logic [CNT_W-1:0]            w_cnt;
    logic [porm_pkg::WL_W-1:0]   w_wl;
    logic                        w_ovf;
    logic [COORD_BITS-1:0]       w_xl, w_xh, w_yl, w_yh;
    logic                        w_empty;

    assign i_pin.ready = (r_state == S_IDLE);
    assign w_pin_xfer  = i_pin.valid && i_pin.ready;
    assign w_out_xfer  = o_res.valid && o_res.ready;

    // coordinates are taken modulo 2^COORD_BITS
    assign w_x = COORD_BITS'(i_pin.pin_x);
    assign w_y = COORD_BITS'(i_pin.pin_y);

    // result moves into the output register once it is free or being drained
    assign w_load  = (r_state == S_DONE) && (!r_ov || o_res.ready);
    assign w_start = (r_state == S_SUM) && r_last_net && (w_cnt != '0);
    assign w_empty = (w_cnt == '0);

    assign w_acc.pin_take   = w_pin_xfer;
    assign w_acc.fin_span   = (r_state == S_SPAN);
    assign w_acc.fin_sum    = (r_state == S_SUM);
    assign w_acc.clear_cell = w_load;

    porm_net_acc #(
        .MAX_NETS   (MAX_NETS),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_acc),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_self  (i_pin.is_self),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_xlo   (w_xlo),
        .o_xhi   (w_xhi),
        .o_ylo   (w_ylo),
        .o_yhi   (w_yhi),
        .o_cnt   (w_cnt),
        .o_wl    (w_wl),
        .o_ovf   (w_ovf)
    );

    porm_select #(
        .MAX_NETS   (MAX_NETS),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_sel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_xlo     (w_xlo),
        .i_xhi     (w_xhi),
        .i_ylo     (w_ylo),
        .i_yhi     (w_yhi),
        .i_start   (w_start),
        .i_cnt     (w_cnt),
        .o_stat    (w_sel_stat),
        .o_x_lower (w_xl),
        .o_x_upper (w_xh),
        .o_y_lower (w_yl),
        .o_y_upper (w_yh)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_last_net <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_pin_xfer && (i_pin.last_pin || i_pin.last_net)) begin
                        r_last_net <= i_pin.last_net;
                        r_state    <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // an empty list skips the search and reports zero edges
                    if (!r_last_net) begin
                        r_state <= S_IDLE;
                    end else if (w_empty) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (w_sel_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_ov <= 1'b1;
            end else if (w_out_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left   <= w_empty ? '0 : porm_pkg::PORT_W'(w_xl);
            r_right  <= w_empty ? '0 : porm_pkg::PORT_W'(w_xh);
            r_top    <= w_empty ? '0 : porm_pkg::PORT_W'(w_yl);
            r_bottom <= w_empty ? '0 : porm_pkg::PORT_W'(w_yh);
            r_wl     <= w_wl;
            r_ovf    <= w_ovf;
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.left_edge       = r_left;
    assign o_res.right_edge      = r_right;
    assign o_res.top_edge        = r_top;
    assign o_res.bottom_edge     = r_bottom;
    assign o_res.cell_wirelength = r_wl;
    assign o_res.net_overflow    = r_ovf;

    a_list_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pin_xfer && i_pin.last_net) |=> !i_pin.ready)
        else $error("pin taken right after end of list");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CNT_W'(MAX_NETS))
        else $error("stored net count above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ovf |-> (w_cnt == CNT_W'(MAX_NETS)))
        else $error("overflow flagged with room left");

    a_sel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> w_sel_stat.busy)
        else $error("sequencer waits on an idle median unit");

    a_done_in_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sel_stat.done |-> (r_state == S_SEL))
        else $error("median done outside search state");

endmodule

[hw/rtl/porm_net_acc.sv]
module porm_net_acc #(
    parameter int MAX_NETS   = 32,
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  porm_pkg::t_acc_ctrl       i_ctrl,
    input  logic [COORD_BITS-1:0]     i_x,
    input  logic [COORD_BITS-1:0]     i_y,
    input  logic                      i_self,
    output logic                      o_we,
    output logic [IDX_W-1:0]          o_waddr,
    output logic [COORD_BITS-1:0]     o_xlo,
    output logic [COORD_BITS-1:0]     o_xhi,
    output logic [COORD_BITS-1:0]     o_ylo,
    output logic [COORD_BITS-1:0]     o_yhi,
    output logic [CNT_W-1:0]          o_cnt,
    output logic [porm_pkg::WL_W-1:0] o_wl,
    output logic                      o_ovf
);

    localparam logic [COORD_BITS-1:0] SENTINEL = '1;
    localparam logic [CNT_W-1:0]      CAP      = CNT_W'(MAX_NETS);
    localparam int SUM_W = (COORD_BITS + 2 > porm_pkg::WL_W + 1) ?
                           COORD_BITS + 2 : porm_pkg::WL_W + 1;

    logic [COORD_BITS-1:0]     r_xmin, r_xmax, r_ymin, r_ymax;
    logic [COORD_BITS-1:0]     r_sx, r_sy;
    logic                      r_seen;
    logic [COORD_BITS-1:0]     r_spx, r_spy;
    logic                      r_keep;
    logic [CNT_W-1:0]          r_cnt;
    logic [porm_pkg::WL_W-1:0] r_wl;
    logic                      r_ovf;

    logic                      w_full;
    logic [COORD_BITS-1:0]     w_ixmin, w_ixmax, w_iymin, w_iymax;
    logic [COORD_BITS-1:0]     w_spx, w_spy;
    logic [SUM_W-1:0]          w_sum;

    assign w_full = (r_cnt == CAP);

    // box including the cell, once its position is known
    assign w_ixmin = (r_seen && r_sx < r_xmin) ? r_sx : r_xmin;
    assign w_ixmax = (r_seen && r_sx > r_xmax) ? r_sx : r_xmax;
    assign w_iymin = (r_seen && r_sy < r_ymin) ? r_sy : r_ymin;
    assign w_iymax = (r_seen && r_sy > r_ymax) ? r_sy : r_ymax;

    // absolute spans: an empty box has min above max
    assign w_spx = (w_ixmax >= w_ixmin) ? w_ixmax - w_ixmin : w_ixmin - w_ixmax;
    assign w_spy = (w_iymax >= w_iymin) ? w_iymax - w_iymin : w_iymin - w_iymax;

    assign w_sum = SUM_W'(r_wl) + SUM_W'(r_spx) + SUM_W'(r_spy);

    assign o_we    = i_ctrl.fin_span && !w_full;
    assign o_waddr = r_cnt[IDX_W-1:0];
    assign o_xlo   = r_xmin;
    assign o_xhi   = r_xmax;
    assign o_ylo   = r_ymin;
    assign o_yhi   = r_ymax;
    assign o_cnt   = r_cnt;
    assign o_wl    = r_wl;
    assign o_ovf   = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= SENTINEL;
            r_xmax <= '0;
            r_ymin <= SENTINEL;
            r_ymax <= '0;
            r_seen <= 1'b0;
            r_keep <= 1'b0;
            r_cnt  <= '0;
            r_wl   <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_ctrl.pin_take) begin
                if (i_self) begin
                    r_seen <= 1'b1;
                end else begin
                    if (i_x < r_xmin) r_xmin <= i_x;
                    if (i_x > r_xmax) r_xmax <= i_x;
                    if (i_y < r_ymin) r_ymin <= i_y;
                    if (i_y > r_ymax) r_ymax <= i_y;
                end
            end
            if (i_ctrl.fin_span) begin
                r_keep <= !w_full;
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_xmin <= SENTINEL;
                r_xmax <= '0;
                r_ymin <= SENTINEL;
                r_ymax <= '0;
            end
            if (i_ctrl.fin_sum && r_keep) begin
                if (w_sum > SUM_W'(porm_pkg::WL_MAX)) begin
                    r_wl <= porm_pkg::WL_MAX;
                end else begin
                    r_wl <= w_sum[porm_pkg::WL_W-1:0];
                end
            end
            if (i_ctrl.clear_cell) begin
                r_seen <= 1'b0;
                r_cnt  <= '0;
                r_wl   <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    // payload: self position and spans
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pin_take && i_self) begin
            r_sx <= i_x;
            r_sy <= i_y;
        end
        if (i_ctrl.fin_span) begin
            r_spx <= w_spx;
            r_spy <= w_spy;
        end
    end

endmodule

[hw/rtl/porm_select.sv]
module porm_select #(
    parameter int MAX_NETS   = 32,
    parameter int COORD_BITS = 16,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [COORD_BITS-1:0] i_xlo,
    input  logic [COORD_BITS-1:0] i_xhi,
    input  logic [COORD_BITS-1:0] i_ylo,
    input  logic [COORD_BITS-1:0] i_yhi,
    input  logic                  i_start,
    input  logic [CNT_W-1:0]      i_cnt,
    output porm_pkg::t_sel_stat   o_stat,
    output logic [COORD_BITS-1:0] o_x_lower,
    output logic [COORD_BITS-1:0] o_x_upper,
    output logic [COORD_BITS-1:0] o_y_lower,
    output logic [COORD_BITS-1:0] o_y_upper
);

    localparam int SCAN_W = IDX_W + 1;   // index over the 2N bounds
    localparam int RANK_W = CNT_W + 1;   // rank counts up to 2N

    localparam logic [2:0] SL_IDLE = 3'd0;
    localparam logic [2:0] SL_CRD  = 3'd1;
    localparam logic [2:0] SL_CLD  = 3'd2;
    localparam logic [2:0] SL_SCAN = 3'd3;
    localparam logic [2:0] SL_EVAL = 3'd4;

    // bound stores: one entry per stored net, min and max kept apart
    logic [COORD_BITS-1:0] m_xlo [MAX_NETS];
    logic [COORD_BITS-1:0] m_xhi [MAX_NETS];
    logic [COORD_BITS-1:0] m_ylo [MAX_NETS];
    logic [COORD_BITS-1:0] m_yhi [MAX_NETS];

    logic [2:0]            r_state;
    logic                  r_axis;
    logic [SCAN_W-1:0]     r_cand, r_j;
    logic                  r_iss_done, r_dv, r_dlsb;
    logic [COORD_BITS-1:0] r_cval;
    logic [RANK_W-1:0]     r_lt, r_le;
    logic [COORD_BITS-1:0] r_rxl, r_rxh, r_ryl, r_ryh;
    logic [COORD_BITS-1:0] r_xl, r_xh, r_yl, r_yh;

    logic [SCAN_W-1:0]     w_last;
    logic [IDX_W-1:0]      w_raddr;
    logic                  w_rlsb;
    logic [COORD_BITS-1:0] w_rdata;
    logic [RANK_W-1:0]     w_n;
    logic                  w_hit_lo, w_hit_hi;
    logic                  w_cand_end;

    assign w_last  = SCAN_W'({i_cnt, 1'b0} - 1'b1);
    assign w_raddr = (r_state == SL_CRD) ? r_cand[SCAN_W-1:1] : r_j[SCAN_W-1:1];
    assign w_rlsb  = (r_state == SL_CRD) ? r_cand[0] : r_j[0];
    assign w_rdata = r_axis ? (r_dlsb ? r_ryh : r_ryl) : (r_dlsb ? r_rxh : r_rxl);

    // candidate is the lower median when lt <= N-1 < le, upper when lt <= N < le
    assign w_n      = RANK_W'(i_cnt);
    assign w_hit_lo = (r_lt < w_n) && (w_n <= r_le);
    assign w_hit_hi = (r_lt <= w_n) && (w_n < r_le);
    assign w_cand_end = (r_cand == w_last);

    assign o_stat.busy = (r_state != SL_IDLE);
    assign o_stat.done = (r_state == SL_EVAL) && w_cand_end && r_axis;
    assign o_x_lower   = r_xl;
    assign o_x_upper   = r_xh;
    assign o_y_lower   = r_yl;
    assign o_y_upper   = r_yh;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            m_xlo[i_waddr] <= i_xlo;
            m_xhi[i_waddr] <= i_xhi;
            m_ylo[i_waddr] <= i_ylo;
            m_yhi[i_waddr] <= i_yhi;
        end
        r_rxl  <= m_xlo[w_raddr];
        r_rxh  <= m_xhi[w_raddr];
        r_ryl  <= m_ylo[w_raddr];
        r_ryh  <= m_yhi[w_raddr];
        r_dlsb <= w_rlsb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SL_IDLE;
            r_axis     <= 1'b0;
            r_cand     <= '0;
            r_j        <= '0;
            r_iss_done <= 1'b0;
            r_dv       <= 1'b0;
            r_lt       <= '0;
            r_le       <= '0;
        end else begin
            unique case (r_state)
                SL_IDLE: begin
                    if (i_start) begin
                        r_axis  <= 1'b0;
                        r_cand  <= '0;
                        r_state <= SL_CRD;
                    end
                end
                SL_CRD: begin
                    r_state <= SL_CLD;
                end
                SL_CLD: begin
                    r_cval     <= w_rdata;
                    r_j        <= '0;
                    r_iss_done <= 1'b0;
                    r_dv       <= 1'b0;
                    r_lt       <= '0;
                    r_le       <= '0;
                    r_state    <= SL_SCAN;
                end
                SL_SCAN: begin
                    // issue one read a cycle, compare each in the cycle after
                    r_dv <= !r_iss_done;
                    if (!r_iss_done) begin
                        if (r_j == w_last) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        if (w_rdata < r_cval) begin
                            r_lt <= r_lt + 1'b1;
                            r_le <= r_le + 1'b1;
                        end else if (w_rdata == r_cval) begin
                            r_le <= r_le + 1'b1;
                        end
                    end
                    if (r_iss_done && !r_dv) begin
                        r_state <= SL_EVAL;
                    end
                end
                SL_EVAL: begin
                    if (w_cand_end) begin
                        r_cand <= '0;
                        if (r_axis) begin
                            r_state <= SL_IDLE;
                        end else begin
                            r_axis  <= 1'b1;
                            r_state <= SL_CRD;
                        end
                    end else begin
                        r_cand  <= r_cand + 1'b1;
                        r_state <= SL_CRD;
                    end
                end
                default: begin
                    r_state <= SL_IDLE;
                end
            endcase
        end
    end

    // median registers
    always_ff @(posedge i_clk) begin
        if (r_state == SL_EVAL) begin
            if (r_axis) begin
                if (w_hit_lo) r_yl <= r_cval;
                if (w_hit_hi) r_yh <= r_cval;
            end else begin
                if (w_hit_lo) r_xl <= r_cval;
                if (w_hit_hi) r_xh <= r_cval;
            end
        end
    end

    a_done_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> (r_state == SL_IDLE))
        else $error("select done did not return to idle");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SL_SCAN) |-> (r_le <= RANK_W'({i_cnt, 1'b0})))
        else $error("rank count exceeds number of bounds");

    a_lt_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SL_EVAL) |-> (r_lt < r_le))
        else $error("candidate not counted against itself");

endmodule

[tb/placement_optimal_region_median_core_tb.sv]
`timescale 1ns / 100ps

module placement_optimal_region_median_core_tb;

    localparam int PORT_W = porm_pkg::PORT_W;
    localparam int WL_W   = porm_pkg::WL_W;
    localparam logic [WL_W-1:0] WL_MAX = porm_pkg::WL_MAX;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 10;
    // The limit covers every planned cell at the cost of the slowest
    // search, that of a full cell, with room to spare.
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int MAX_NETS     = 32;
    localparam int STORE_DEPTH  = 2 * MAX_NETS;
    localparam int AXIS_X       = 0;
    localparam int AXIS_Y       = 1;
    localparam logic [PORT_W-1:0] COORD_TOP = 16'd65534;
    localparam logic [PORT_W-1:0] SENTINEL  = '1;

    typedef struct {
        logic [PORT_W-1:0] left_edge;
        logic [PORT_W-1:0] right_edge;
        logic [PORT_W-1:0] top_edge;
        logic [PORT_W-1:0] bottom_edge;
        logic [WL_W-1:0]   cell_wirelength;
        logic              net_overflow;
    } t_region;

    logic i_clk = 1'b0;
    logic i_rst_n;

    porm_pin_if pin_bus ();
    porm_res_if res_bus ();

    placement_optimal_region_median_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pin   (pin_bus),
        .o_res   (res_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Region predictor: per-cell state mirrored from the block's behavior
    // ------------------------------------------------------------------
    logic [PORT_W-1:0] box_x_lo, box_x_hi, box_y_lo, box_y_hi;  // box without the cell
    logic [PORT_W-1:0] self_x, self_y;
    bit                self_known;
    logic [PORT_W-1:0] bound_store [2][STORE_DEPTH];              // [axis][2*net + lo/hi]
    int                nets_kept;
    int                wl_total;
    bit                nets_dropped;

    t_region expected_regions [$];

    int  fail_count  = 0;
    int  pin_count   = 0;
    int  cycle_count = 0;
    bit  idling      = 1'b0;  // random gaps on both channels when set
    logic [PORT_W-1:0] cell_base;  // clusters coordinates so medians see ties

    task automatic clear_net_box();
        box_x_lo = SENTINEL;
        box_x_hi = '0;
        box_y_lo = SENTINEL;
        box_y_hi = '0;
    endtask

    task automatic clear_cell_state();
        clear_net_box();
        self_x       = '0;
        self_y       = '0;
        self_known   = 1'b0;
        nets_kept    = 0;
        wl_total     = 0;
        nets_dropped = 1'b0;
    endtask

    function automatic int abs_diff(input logic [PORT_W-1:0] a, input logic [PORT_W-1:0] b);
        return (a >= b) ? int'(a - b) : int'(b - a);
    endfunction

    // Net end: if room is left, store excluding bounds and add including half-perimeter.
    task automatic close_net();
        logic [PORT_W-1:0] xl, xh, yl, yh;
        if (nets_kept >= MAX_NETS) begin
            nets_dropped = 1'b1;
        end else begin
            xl = box_x_lo;
            xh = box_x_hi;
            yl = box_y_lo;
            yh = box_y_hi;
            bound_store[AXIS_X][2 * nets_kept]     = xl;
            bound_store[AXIS_X][2 * nets_kept + 1] = xh;
            bound_store[AXIS_Y][2 * nets_kept]     = yl;
            bound_store[AXIS_Y][2 * nets_kept + 1] = yh;
            nets_kept++;
            if (self_known) begin
                if (self_x < xl) xl = self_x;
                if (self_x > xh) xh = self_x;
                if (self_y < yl) yl = self_y;
                if (self_y > yh) yh = self_y;
            end
            wl_total += abs_diff(xl, xh) + abs_diff(yl, yh);
            if (wl_total > int'(WL_MAX))
                wl_total = int'(WL_MAX);
        end
        clear_net_box();
    endtask

    // Lower and upper middle of the 2N stored bounds of one axis.
    task automatic middle_pair(input int axis, output logic [PORT_W-1:0] lo,
                               output logic [PORT_W-1:0] hi);
        logic [PORT_W-1:0] work [STORE_DEPTH];
        logic [PORT_W-1:0] v;
        int i, j;
        if (nets_kept == 0) begin
            lo = '0;
            hi = '0;
        end else begin
            for (i = 0; i < 2 * nets_kept; i++)
                work[i] = bound_store[axis][i];
            for (i = 1; i < 2 * nets_kept; i++) begin
                v = work[i];
                j = i;
                while (j > 0 && work[j-1] > v) begin
                    work[j] = work[j-1];
                    j--;
                end
                work[j] = v;
            end
            lo = work[nets_kept - 1];
            hi = work[nets_kept];
        end
    endtask

    // Apply one accepted pin; a list end queues the region it produces.
    task automatic track_pin(input logic [PORT_W-1:0] x, input logic [PORT_W-1:0] y,
                             input logic is_self, input logic last_pin, input logic last_net);
        t_region r;
        if (is_self) begin
            self_x     = x;
            self_y     = y;
            self_known = 1'b1;
        end else begin
            if (x < box_x_lo) box_x_lo = x;
            if (x > box_x_hi) box_x_hi = x;
            if (y < box_y_lo) box_y_lo = y;
            if (y > box_y_hi) box_y_hi = y;
        end
        if (last_pin || last_net)
            close_net();
        if (last_net) begin
            middle_pair(AXIS_X, r.left_edge, r.right_edge);
            middle_pair(AXIS_Y, r.top_edge, r.bottom_edge);
            r.cell_wirelength = wl_total[WL_W-1:0];
            r.net_overflow    = nets_dropped;
            expected_regions.push_back(r);
            clear_cell_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Pin channel driver: one transfer, then maybe a random gap
    // ------------------------------------------------------------------
    task automatic send_pin(input logic [PORT_W-1:0] x, input logic [PORT_W-1:0] y,
                            input logic is_self, input logic last_pin, input logic last_net);
        pin_bus.valid    <= 1'b1;
        pin_bus.pin_x    <= x;
        pin_bus.pin_y    <= y;
        pin_bus.is_self  <= is_self;
        pin_bus.last_pin <= last_pin;
        pin_bus.last_net <= last_net;
        do @(posedge i_clk); while (!pin_bus.ready);
        track_pin(x, y, is_self, last_pin, last_net);
        pin_count++;
        if (idling && $urandom_range(0, 3) == 0) begin
            pin_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Extremes, a local cluster for ties, or anything in range.
    function automatic logic [PORT_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COORD_TOP;
            2, 3:    return cell_base + PORT_W'($urandom_range(0, 63));
            default: return PORT_W'($urandom_range(0, 65534));
        endcase
    endfunction

    // Well-formed cell: nets of 1..pins_max pins, usually one self pin
    // somewhere in the net, sometimes none or an extra one.
    task automatic send_cell(input int nets, input int pins_max);
        int   n, i, k, self_at;
        logic is_self, lp, ln;
        cell_base = PORT_W'($urandom_range(0, 65534 - 63));
        for (n = 0; n < nets; n++) begin
            k       = $urandom_range(1, pins_max);
            self_at = $urandom_range(0, k);  // k: no self pin in this net
            for (i = 0; i < k; i++) begin
                is_self = (i == self_at) || ($urandom_range(0, 15) == 0);
                ln      = (n == nets - 1) && (i == k - 1);
                lp      = (i == k - 1);
                if (ln)
                    lp = ($urandom_range(0, 1) == 1);  // list end closes the net either way
                send_pin(rand_coord(), rand_coord(), is_self, lp, ln);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-pin cells: plain pin, self-only net (sentinel box plus the cell),
    // list end without last_pin.
    task automatic test_lone_pins();
        send_pin('0, '0, 1'b0, 1'b1, 1'b1);
        send_pin(COORD_TOP, COORD_TOP, 1'b1, 1'b0, 1'b1);
        send_pin(COORD_TOP, '0, 1'b0, 1'b0, 1'b1);
    endtask

    // Full-range box, a net with only the cell, a net that uses the cell
    // position from an earlier net, and alternating bit patterns.
    task automatic test_box_extremes();
        send_pin('0, COORD_TOP, 1'b0, 1'b0, 1'b0);
        send_pin(COORD_TOP, '0, 1'b0, 1'b0, 1'b0);
        send_pin(16'd32768, 16'd16384, 1'b1, 1'b1, 1'b0);
        send_pin(16'd100, 16'd200, 1'b1, 1'b1, 1'b0);
        send_pin(16'd40000, 16'd40000, 1'b0, 1'b1, 1'b0);
        send_pin(16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0);
        send_pin(16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b1);
    endtask

    // Cell moves mid-net: the latest self pin wins, even before net end.
    task automatic test_self_tracking();
        send_pin(16'd10, 16'd10, 1'b1, 1'b0, 1'b0);
        send_pin(16'd20, 16'd20, 1'b0, 1'b1, 1'b0);
        send_pin(16'd5, 16'd5, 1'b0, 1'b0, 1'b0);
        send_pin(16'd30, 16'd30, 1'b1, 1'b0, 1'b0);
        send_pin(16'd7, 16'd9, 1'b0, 1'b1, 1'b1);
    endtask

    // Exactly full store, then enough nets to drop a few.
    task automatic test_capacity();
        send_cell(MAX_NETS, 1);
        send_cell(MAX_NETS + 3, 2);
    endtask

    // Mostly small cells; now and then one near or past capacity.
    // Gaps stop for the final stretch of the run.
    task automatic test_random_cells(input int pin_goal);
        int quiet_from;
        quiet_from = pin_goal - 120;
        while (pin_count < pin_goal) begin
            idling = (pin_count < quiet_from) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 11) == 0)
                send_cell($urandom_range(MAX_NETS - 4, MAX_NETS + 4), 2);
            else
                send_cell($urandom_range(1, 6), 5);
        end
        idling = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result channel: random back-pressure while idling is on
    // ------------------------------------------------------------------
    initial begin : result_sink
        res_bus.ready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        res_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 2) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Every result transfer is matched against the oldest queued region.
    always @(posedge i_clk) begin : check_results
        t_region want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (expected_regions.size() == 0) begin
                $error("result transfer with no region expected");
                fail_count++;
            end else begin
                want = expected_regions.pop_front();
                compare_field("left_edge", 32'(want.left_edge), 32'(res_bus.left_edge));
                compare_field("right_edge", 32'(want.right_edge), 32'(res_bus.right_edge));
                compare_field("top_edge", 32'(want.top_edge), 32'(res_bus.top_edge));
                compare_field("bottom_edge", 32'(want.bottom_edge),
                              32'(res_bus.bottom_edge));
                compare_field("cell_wirelength", 32'(want.cell_wirelength),
                              32'(res_bus.cell_wirelength));
                compare_field("net_overflow", 32'(want.net_overflow),
                              32'(res_bus.net_overflow));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("placement_optimal_region_median_core_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        pin_bus.valid    <= 1'b0;
        pin_bus.pin_x    <= '0;
        pin_bus.pin_y    <= '0;
        pin_bus.is_self  <= 1'b0;
        pin_bus.last_pin <= 1'b0;
        pin_bus.last_net <= 1'b0;
        clear_cell_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idling  = 1'b1;

        test_lone_pins();
        test_box_extremes();
        test_self_tracking();
        test_capacity();
        test_random_cells(pin_count + 680);

        pin_bus.valid <= 1'b0;
        // wait out the median search of the last cell
        while (expected_regions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("placement_optimal_region_median_core_tb passed");
        else
            $display("placement_optimal_region_median_core_tb failed");
        $finish;
    end

endmodule
